### src/cwlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwlp_pkg
// Shared constants, types and helpers for the weight layout permuter.
// ----------------------------------------------------------------------------
package cwlp_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int MAX_SIDE     = 16;

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CH_CFG_W   = 13;
    localparam int SIDE_CFG_W = 5;

    // clamped dimensions and position counters
    localparam int CH_DIM_W   = $clog2(MAX_CHANNELS + 1);
    localparam int SIDE_DIM_W = $clog2(MAX_SIDE + 1);
    localparam int CH_POS_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SIDE_POS_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int MUL_W      = (CH_DIM_W > SIDE_DIM_W) ? CH_DIM_W : SIDE_DIM_W;
    localparam int ADD_W      = (CH_POS_W > SIDE_POS_W) ? CH_POS_W : SIDE_POS_W;

    localparam int ELEM_SHIFT = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTHWISE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES    = 3'd5;

    // index = ((start * mul1 + add1) * mul2 + add2) * mul3 + add3
    typedef struct packed {
        logic [CH_POS_W-1:0]   start;
        logic [SIDE_DIM_W-1:0] mul1;
        logic [SIDE_POS_W-1:0] add1;
        logic [SIDE_DIM_W-1:0] mul2;
        logic [SIDE_POS_W-1:0] add2;
        logic [CH_DIM_W-1:0]   mul3;
        logic [CH_POS_W-1:0]   add3;
        logic                  quad;
        logic [DATA_W-1:0]     data;
        logic                  last;
        logic                  bad;
    } cwlp_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DONE
    } cwlp_back_state_t;

    typedef enum logic [1:0] {
        STEP_ROW,
        STEP_COL,
        STEP_CHAN
    } cwlp_step_t;

    function automatic logic [CH_DIM_W-1:0] clamp_chan(input logic [CH_CFG_W-1:0] v);
        logic [CH_DIM_W-1:0] r;
        if (v == '0) begin
            r = CH_DIM_W'(1);
        end else if (32'(v) > MAX_CHANNELS) begin
            r = CH_DIM_W'(MAX_CHANNELS);
        end else begin
            r = CH_DIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [SIDE_DIM_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
        logic [SIDE_DIM_W-1:0] r;
        if (v == '0) begin
            r = SIDE_DIM_W'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = SIDE_DIM_W'(MAX_SIDE);
        end else begin
            r = SIDE_DIM_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/cwlp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwlp_fifo
// Short register queue carrying address jobs from front to back.
// ----------------------------------------------------------------------------
module cwlp_fifo import cwlp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cwlp_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output cwlp_job_t head_job
);

    cwlp_job_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

### src/cwlp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwlp_front
// Configuration registers, source position counters and job classification.
// ----------------------------------------------------------------------------
module cwlp_front import cwlp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_element_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output cwlp_job_t             q_job
);

    logic [CH_CFG_W-1:0]   out_channels_reg, out_channels_next;
    logic [CH_CFG_W-1:0]   in_channels_reg, in_channels_next;
    logic [SIDE_CFG_W-1:0] kernel_height_reg, kernel_height_next;
    logic [SIDE_CFG_W-1:0] kernel_width_reg, kernel_width_next;
    logic                  depthwise_reg, depthwise_next;
    logic                  elem_bytes_reg, elem_bytes_next;

    logic [CH_POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [CH_POS_W-1:0]   in_pos_reg, in_pos_next;
    logic [SIDE_POS_W-1:0] row_pos_reg, row_pos_next;
    logic [SIDE_POS_W-1:0] col_pos_reg, col_pos_next;

    logic [CH_DIM_W-1:0]   n_out, n_in;
    logic [SIDE_DIM_W-1:0] n_row, n_col;
    logic                  last_o, last_i, last_h, last_w;
    logic                  accept, cfg_hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    assign n_out = clamp_chan(out_channels_reg);
    assign n_in  = clamp_chan(in_channels_reg);
    assign n_row = clamp_side(kernel_height_reg);
    assign n_col = clamp_side(kernel_width_reg);

    assign last_o = ((CH_DIM_W+1)'(out_pos_reg) + 1'b1) >= (CH_DIM_W+1)'(n_out);
    assign last_i = ((CH_DIM_W+1)'(in_pos_reg) + 1'b1) >= (CH_DIM_W+1)'(n_in);
    assign last_h = ((SIDE_DIM_W+1)'(row_pos_reg) + 1'b1) >= (SIDE_DIM_W+1)'(n_row);
    assign last_w = ((SIDE_DIM_W+1)'(col_pos_reg) + 1'b1) >= (SIDE_DIM_W+1)'(n_col);

    // register writes
    always_comb begin
        out_channels_next  = out_channels_reg;
        in_channels_next   = in_channels_reg;
        kernel_height_next = kernel_height_reg;
        kernel_width_next  = kernel_width_reg;
        depthwise_next     = depthwise_reg;
        elem_bytes_next    = elem_bytes_reg;
        cfg_hit            = 1'b0;
        if (cfg_valid) begin
            cfg_hit = 1'b1;
            case (cfg_index)
                REG_OUT_CHANNELS:  out_channels_next  = cfg_data[CH_CFG_W-1:0];
                REG_IN_CHANNELS:   in_channels_next   = cfg_data[CH_CFG_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_next = cfg_data[SIDE_CFG_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_next  = cfg_data[SIDE_CFG_W-1:0];
                REG_DEPTHWISE:     depthwise_next     = cfg_data[0];
                REG_ELEM_BYTES:    elem_bytes_next    = cfg_data[0];
                default:           cfg_hit            = 1'b0;
            endcase
        end
    end

    // source order counters, column fastest
    always_comb begin
        out_pos_next = out_pos_reg;
        in_pos_next  = in_pos_reg;
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_hit) begin
            out_pos_next = '0;
            in_pos_next  = '0;
            row_pos_next = '0;
            col_pos_next = '0;
        end else if (accept) begin
            col_pos_next = last_w ? '0 : col_pos_reg + 1'b1;
            if (last_w) begin
                row_pos_next = last_h ? '0 : row_pos_reg + 1'b1;
                if (last_h) begin
                    in_pos_next = last_i ? '0 : in_pos_reg + 1'b1;
                    if (last_i) begin
                        out_pos_next = last_o ? '0 : out_pos_reg + 1'b1;
                    end
                end
            end
        end
    end

    // standard: ((o*H+h)*W+w)*C+i, depthwise: ((0*H+h)*W+w)*O+o
    always_comb begin
        q_job.start = depthwise_reg ? '0 : out_pos_reg;
        q_job.mul1  = n_row;
        q_job.add1  = row_pos_reg;
        q_job.mul2  = n_col;
        q_job.add2  = col_pos_reg;
        q_job.mul3  = depthwise_reg ? n_out : n_in;
        q_job.add3  = depthwise_reg ? out_pos_reg : in_pos_reg;
        q_job.quad  = elem_bytes_reg;
        q_job.data  = s_element_data;
        q_job.last  = last_o && last_i && last_h && last_w;
        q_job.bad   = depthwise_reg && (n_in != CH_DIM_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_channels_reg  <= CH_CFG_W'(1);
            in_channels_reg   <= CH_CFG_W'(1);
            kernel_height_reg <= SIDE_CFG_W'(1);
            kernel_width_reg  <= SIDE_CFG_W'(1);
            depthwise_reg     <= 1'b0;
            elem_bytes_reg    <= 1'b0;
            out_pos_reg       <= '0;
            in_pos_reg        <= '0;
            row_pos_reg       <= '0;
            col_pos_reg       <= '0;
        end else begin
            out_channels_reg  <= out_channels_next;
            in_channels_reg   <= in_channels_next;
            kernel_height_reg <= kernel_height_next;
            kernel_width_reg  <= kernel_width_next;
            depthwise_reg     <= depthwise_next;
            elem_bytes_reg    <= elem_bytes_next;
            out_pos_reg       <= out_pos_next;
            in_pos_reg        <= in_pos_next;
            row_pos_reg       <= row_pos_next;
            col_pos_reg       <= col_pos_next;
        end
    end

endmodule
`default_nettype wire

### src/cwlp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwlp_back
// Address sequencer: three steps on one multiply-add, then output register.
// ----------------------------------------------------------------------------
module cwlp_back import cwlp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cwlp_job_t         q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_byte_address,
    output logic [DATA_W-1:0] m_element_out,
    output logic              m_last_element,
    output logic              m_bad_config
);

    cwlp_back_state_t    state_reg, state_next;
    cwlp_step_t          step_reg, step_next;
    cwlp_job_t           job_reg;
    logic [ADDR_W-1:0]   acc_reg;
    logic                m_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                last_reg, bad_reg;

    logic                out_free, load_out;
    logic [MUL_W-1:0]    mul_op;
    logic [ADD_W-1:0]    add_op;
    logic [ADDR_W+MUL_W-1:0] prod;
    logic [ADDR_W-1:0]   mac_next;
    logic [ADDR_W-1:0]   addr_scaled;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_MAC;
                end
            end
            BK_MAC: begin
                if (step_reg == STEP_CHAN) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop    = q_valid;
            BK_DONE: load_out = out_free;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (step_reg)
            STEP_ROW: begin
                mul_op    = MUL_W'(job_reg.mul1);
                add_op    = ADD_W'(job_reg.add1);
                step_next = STEP_COL;
            end
            STEP_COL: begin
                mul_op    = MUL_W'(job_reg.mul2);
                add_op    = ADD_W'(job_reg.add2);
                step_next = STEP_CHAN;
            end
            default: begin
                mul_op    = MUL_W'(job_reg.mul3);
                add_op    = ADD_W'(job_reg.add3);
                step_next = STEP_ROW;
            end
        endcase
    end

    assign prod        = acc_reg * mul_op;
    assign mac_next    = prod[ADDR_W-1:0] + ADDR_W'(add_op);
    assign addr_scaled = job_reg.quad ? (acc_reg << ELEM_SHIFT) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            step_reg    <= STEP_ROW;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                step_reg <= STEP_ROW;
            end else if (state_reg == BK_MAC) begin
                step_reg <= step_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
            acc_reg <= ADDR_W'(q_job.start);
        end else if (state_reg == BK_MAC) begin
            acc_reg <= mac_next;
        end
        if (load_out) begin
            addr_reg <= addr_scaled;
            data_reg <= job_reg.data;
            last_reg <= job_reg.last;
            bad_reg  <= job_reg.bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = addr_reg;
    assign m_element_out  = data_reg;
    assign m_last_element = last_reg;
    assign m_bad_config   = bad_reg;

endmodule
`default_nettype wire

### src/conv_weight_layout_permute.sv
`default_nettype none
// flow: an accepted element is queued, then the back sequencer pops it, makes three passes
// through its shared multiply-add and loads the output register; it handles one element
// at a time and holds in its done state while the output stalls; the 2-entry queue absorbs bursts
// reset: synchronous active-low aresetn; registers return to 1x1x1x1, standard
// layout, one-byte elements; counters, queue and output valid cleared
// ----------------------------------------------------------------------------
// conv_weight_layout_permute
// Streams convolution weights and gives each one its byte address in the
// permuted (channel-last or depthwise) layout.
// ----------------------------------------------------------------------------
module conv_weight_layout_permute import cwlp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_element_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_byte_address,
    output logic [DATA_W-1:0]     m_element_out,
    output logic                  m_last_element,
    output logic                  m_bad_config,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      q_full, q_push, q_pop, q_valid;
    cwlp_job_t push_job, head_job;

    cwlp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_data (s_element_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    cwlp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    cwlp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_job          (head_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_bad_config   (m_bad_config)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the weight layout permuter against a cycle-free placement
// predictor: directed tensors for reset values, both layouts, both element
// sizes, clamped and zero dimensions and the spare register slots, then
// random tensor shapes with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import cwlp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              bad;
    } placement_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_element_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ADDR_W-1:0]     m_byte_address;
    logic [DATA_W-1:0]     m_element_out;
    logic                  m_last_element;
    logic                  m_bad_config;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and the source position counters
    logic [CH_CFG_W-1:0]   cfg_out = 13'd1;
    logic [CH_CFG_W-1:0]   cfg_in = 13'd1;
    logic [SIDE_CFG_W-1:0] cfg_rows = 5'd1;
    logic [SIDE_CFG_W-1:0] cfg_cols = 5'd1;
    logic                  cfg_depthwise = 1'b0;
    logic                  cfg_quad = 1'b0;
    longint unsigned       pos_out = 0, pos_in = 0, pos_row = 0, pos_col = 0;

    placement_t pending_placements[$];
    int         mismatches = 0;
    bit         steady_flow = 1'b0;
    int         stall_left = 0;

    conv_weight_layout_permute dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_data (s_element_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_bad_config   (m_bad_config),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint unsigned clamp_count(input longint unsigned v,
                                                    input longint unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic longint unsigned tensor_elements();
        return clamp_count(cfg_out, MAX_CHANNELS) * clamp_count(cfg_in, MAX_CHANNELS)
             * clamp_count(cfg_rows, MAX_SIDE) * clamp_count(cfg_cols, MAX_SIDE);
    endfunction

    // destination of the element at the current source position, then step
    function automatic placement_t place_element(input logic [DATA_W-1:0] data);
        longint unsigned n_out, n_in, n_row, n_col, index;
        bit              end_col, end_row, end_in, end_out;
        placement_t      p;
        n_out = clamp_count(cfg_out, MAX_CHANNELS);
        n_in  = clamp_count(cfg_in, MAX_CHANNELS);
        n_row = clamp_count(cfg_rows, MAX_SIDE);
        n_col = clamp_count(cfg_cols, MAX_SIDE);
        end_col = (pos_col + 1 >= n_col);
        end_row = (pos_row + 1 >= n_row);
        end_in  = (pos_in + 1 >= n_in);
        end_out = (pos_out + 1 >= n_out);
        if (cfg_depthwise) begin
            index = (pos_row * n_col + pos_col) * n_out + pos_out;
        end else begin
            index = ((pos_out * n_row + pos_row) * n_col + pos_col) * n_in + pos_in;
        end
        if (cfg_quad) begin
            index = index << ELEM_SHIFT;
        end
        p.addr = index[ADDR_W-1:0];
        p.data = data;
        p.last = end_col && end_row && end_in && end_out;
        p.bad  = cfg_depthwise && (n_in != 1);
        if (!end_col) begin
            pos_col++;
        end else begin
            pos_col = 0;
            if (!end_row) begin
                pos_row++;
            end else begin
                pos_row = 0;
                if (!end_in) begin
                    pos_in++;
                end else begin
                    pos_in = 0;
                    pos_out = end_out ? 0 : pos_out + 1;
                end
            end
        end
        return p;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int                    pick;
        v = CFG_DATA_W'($urandom);
        pick = $urandom_range(0, 9);
        case (idx)
            REG_OUT_CHANNELS, REG_IN_CHANNELS: begin
                case (pick)
                    0: v = '0;
                    1: v = CFG_DATA_W'(MAX_CHANNELS);
                    2: v = CFG_DATA_W'($urandom_range(MAX_CHANNELS + 1, 8191));
                    3: v = CFG_DATA_W'($urandom_range(1, MAX_CHANNELS));
                    default: v = CFG_DATA_W'($urandom_range(1, 4));
                endcase
            end
            REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH: begin
                // upper bits of the write data are don't-care for side registers
                case (pick)
                    0: v[SIDE_CFG_W-1:0] = '0;
                    1: v[SIDE_CFG_W-1:0] = SIDE_CFG_W'(MAX_SIDE);
                    2: v[SIDE_CFG_W-1:0] = SIDE_CFG_W'($urandom_range(MAX_SIDE + 1, 31));
                    3: v[SIDE_CFG_W-1:0] = SIDE_CFG_W'($urandom_range(1, MAX_SIDE));
                    default: v[SIDE_CFG_W-1:0] = SIDE_CFG_W'($urandom_range(1, 3));
                endcase
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        placement_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_placements.size() == 0) begin
                note_mismatch("result with no request pending", '0, m_byte_address);
            end else begin
                want = pending_placements.pop_front();
                if (m_byte_address !== want.addr) begin
                    note_mismatch("byte_address", want.addr, m_byte_address);
                end
                if (m_element_out !== want.data) begin
                    note_mismatch("element_out", want.data, m_element_out);
                end
                if (m_last_element !== want.last) begin
                    note_mismatch("last_element", want.last, m_last_element);
                end
                if (m_bad_config !== want.bad) begin
                    note_mismatch("bad_config", want.bad, m_bad_config);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_element(input logic [DATA_W-1:0] data, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_element_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_placements.push_back(place_element(data));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_OUT_CHANNELS:  cfg_out = value[CH_CFG_W-1:0];
            REG_IN_CHANNELS:   cfg_in = value[CH_CFG_W-1:0];
            REG_KERNEL_HEIGHT: cfg_rows = value[SIDE_CFG_W-1:0];
            REG_KERNEL_WIDTH:  cfg_cols = value[SIDE_CFG_W-1:0];
            REG_DEPTHWISE:     cfg_depthwise = value[0];
            REG_ELEM_BYTES:    cfg_quad = value[0];
            default:           ;
        endcase
        // spare slots leave the position counters alone
        if (idx != REG_SPARE_LO && idx != REG_SPARE_HI) begin
            pos_out = 0;
            pos_in  = 0;
            pos_row = 0;
            pos_col = 0;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_element('0, 0);
        send_element('1, 0);
        wait_drained();
    endtask

    task automatic test_standard_layout();
        write_reg(REG_OUT_CHANNELS, 13'd2);
        write_reg(REG_IN_CHANNELS, 13'd2);
        write_reg(REG_KERNEL_HEIGHT, 13'd1);
        write_reg(REG_KERNEL_WIDTH, 13'd2);
        write_reg(REG_ELEM_BYTES, 13'd1);
        repeat (8) send_element($urandom, 0);
        wait_drained();
    endtask

    task automatic test_depthwise_layout();
        // several input channels in depthwise mode raise bad_config
        write_reg(REG_DEPTHWISE, 13'd1);
        write_reg(REG_KERNEL_WIDTH, 13'd1);
        repeat (4) send_element($urandom, 0);
        wait_drained();
        write_reg(REG_IN_CHANNELS, 13'd1);
        repeat (2) send_element($urandom, 0);
        wait_drained();
    endtask

    task automatic test_clamped_dims();
        write_reg(REG_OUT_CHANNELS, '1);
        write_reg(REG_IN_CHANNELS, '0);
        write_reg(REG_KERNEL_HEIGHT, '1);
        write_reg(REG_KERNEL_WIDTH, '0);
        write_reg(REG_DEPTHWISE, '0);
        write_reg(REG_ELEM_BYTES, '0);
        repeat (2) send_element($urandom, 0);
        wait_drained();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, 13'h0AAA);
        send_element($urandom, 0);
        wait_drained();
        write_reg(REG_OUT_CHANNELS, CFG_DATA_W'(MAX_CHANNELS));
        send_element($urandom, 0);
        wait_drained();
    endtask

    task automatic test_random_tensors();
        int              sent, count, r;
        longint unsigned total;
        sent = 0;
        while (sent < 1250) begin
            wait_drained();
            steady_flow = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                for (r = int'(REG_OUT_CHANNELS); r <= int'(REG_ELEM_BYTES); r++) begin
                    write_reg(CFG_IDX_W'(r), reg_value(CFG_IDX_W'(r)));
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom_range(0, 7);
                    write_reg(CFG_IDX_W'(r), reg_value(CFG_IDX_W'(r)));
                end
            end
            total = tensor_elements();
            // whole tensors where they are small enough, otherwise a slice
            if (total <= 96 && $urandom_range(0, 7) != 0) begin
                count = int'(total) * $urandom_range(1, 2);
            end else begin
                count = $urandom_range(1, 40);
            end
            repeat (count) begin
                send_element($urandom,
                             (steady_flow || $urandom_range(0, 2) != 0) ? 0 : pick_gap());
                if ($urandom_range(0, 63) == 0) begin
                    wait_drained();
                end
            end
            sent += count;
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_standard_layout();
        test_depthwise_layout();
        test_clamped_dims();
        test_random_tensors();
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_placements.size() == 0) begin
            $display("conv_weight_layout_permute: match");
        end else begin
            $display("conv_weight_layout_permute: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("conv_weight_layout_permute: mismatch");
        $finish;
    end

endmodule

### sim.f
src/cwlp_pkg.sv
src/cwlp_fifo.sv
src/cwlp_front.sv
src/cwlp_back.sv
src/conv_weight_layout_permute.sv
verif/testbench.sv
